// File: sv/lfsc_pkg.sv
// shared types, tables and helper functions for the lfsr feedback stream cipher
// no dependencies; used by lfsc_round, lfsc_keystream and the top level
package lfsc_pkg;

	localparam int MIX_DEPTH  = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int ROUNDS     = 32;

	// configuration register indexes
	localparam logic REG_KEY_NIBBLES  = 1'b0;
	localparam logic REG_ENCRYPT_MODE = 1'b1;

	localparam logic [7:0] EVEN_MASK = 8'h55;
	localparam logic [7:0] ODD_MASK  = 8'hAA;
	localparam logic [7:0] SEED_TOP  = 8'hff;
	localparam logic [7:0] FIFO_XOR  = 8'hf0;
	localparam logic [3:0] NIB_MASK  = 4'hf;

	typedef logic [7:0] byte_t;
	typedef logic [MIX_DEPTH-1:0][7:0] mix_reg_t;
	typedef logic [FIFO_DEPTH-1:0][7:0] fifo_t;
	typedef logic [7:0][7:0] fold_key_t;

	localparam byte_t ROUND_MASKS [0:15] = '{
		8'h0B, 8'h0A, 8'h78, 8'h0C, 8'hE0, 8'h29, 8'h7B, 8'hCF,
		8'hC3, 8'h4B, 8'h2B, 8'hCC, 8'h82, 8'h60, 8'h80, 8'h06
	};

	localparam byte_t SIX_TO_ONE [0:63] = '{
		8'h96, 8'h4b, 8'h65, 8'h3a, 8'hac, 8'h6c, 8'h53, 8'h74,
		8'h78, 8'ha5, 8'h47, 8'hb2, 8'h4d, 8'ha6, 8'h59, 8'h5a,
		8'h8d, 8'h56, 8'h2b, 8'hc3, 8'h71, 8'hd2, 8'h66, 8'h3c,
		8'h1d, 8'hc9, 8'h93, 8'h2e, 8'ha9, 8'h72, 8'h17, 8'hb1,
		8'hb4, 8'he4, 8'ha3, 8'h4e, 8'h27, 8'h5c, 8'h8b, 8'hc5,
		8'he8, 8'h95, 8'he1, 8'hd1, 8'h87, 8'hb8, 8'h1e, 8'hca,
		8'h1b, 8'h63, 8'hd8, 8'h2d, 8'hd4, 8'h9a, 8'h99, 8'h36,
		8'h8e, 8'hc6, 8'h69, 8'he2, 8'h39, 8'h35, 8'h6a, 8'h9c
	};

	localparam logic [3:0] NIB_SBOX [0:3][0:15] = '{
		'{4'h6, 4'hA, 4'h1, 4'h2, 4'hE, 4'h7, 4'h8, 4'h9,
		  4'hC, 4'h4, 4'h3, 4'hF, 4'hB, 4'h0, 4'h5, 4'hD},
		'{4'h2, 4'h7, 4'h0, 4'h5, 4'hF, 4'h3, 4'h1, 4'h9,
		  4'hE, 4'hD, 4'hB, 4'h8, 4'hC, 4'hA, 4'h4, 4'h6},
		'{4'h9, 4'h1, 4'h3, 4'hC, 4'h2, 4'h0, 4'hA, 4'hE,
		  4'hD, 4'h6, 4'hB, 4'h7, 4'h5, 4'h8, 4'hF, 4'h4},
		'{4'hB, 4'h6, 4'h9, 4'h0, 4'h5, 4'hE, 4'hF, 4'h8,
		  4'h4, 4'hC, 4'h1, 4'hD, 4'h2, 4'h7, 4'h3, 4'hA}
	};

	// nibble t becomes {~t, t}
	function automatic byte_t spread_nib(input logic [3:0] t);
		return {t ^ NIB_MASK, t};
	endfunction

	function automatic byte_t rotl8(input byte_t v, input logic [2:0] n);
		logic [15:0] w;
		w = {v, v} << n;
		return w[15:8];
	endfunction

	function automatic logic [3:0] key_nib(input logic [63:0] key, input logic [3:0] idx);
		return key[idx*4 +: 4];
	endfunction

	function automatic fold_key_t fold_key(input logic [63:0] key);
		fold_key_t fk;
		for (int k = 0; k < 4; k++) begin
			fk[k]   = spread_nib(key_nib(key, 4'(k)) ^ key_nib(key, 4'(k + 4)));
			fk[k+4] = spread_nib(key_nib(key, 4'(k + 8)) ^ key_nib(key, 4'(k + 12)));
		end
		return fk;
	endfunction

endpackage

// File: sv/lfsc_round.sv
// shared mixing round unit: one and-xor round over the sixteen register bytes
// depends on lfsc_pkg
module lfsc_round (
	input  lfsc_pkg::mix_reg_t mix,
	input  logic [4:0]         rc,
	output logic [3:0]         dst,
	output lfsc_pkg::byte_t    new_byte
);

	lfsc_pkg::byte_t acc;
	lfsc_pkg::byte_t folded;

	always_comb begin
		acc = '0;
		for (int k = 0; k < lfsc_pkg::MIX_DEPTH; k++) begin
			acc ^= mix[k] & lfsc_pkg::ROUND_MASKS[4'(rc[3:0] + 4'(k))];
		end
		folded   = ((acc >> 1) ^ acc) & lfsc_pkg::EVEN_MASK;
		dst      = ~rc[3:0];
		new_byte = ((mix[dst] << 1) & lfsc_pkg::ODD_MASK) | folded;
	end

endmodule

// File: sv/lfsc_keystream.sv
// keystream byte former: substitution boxes, six-to-one table and position rotate
// depends on lfsc_pkg
module lfsc_keystream (
	input  lfsc_pkg::mix_reg_t mix,
	input  lfsc_pkg::fifo_t    fifo,
	input  logic [63:0]        key,
	input  logic [2:0]         pos,
	output lfsc_pkg::byte_t    ks
);

	lfsc_pkg::fold_key_t fk;
	lfsc_pkg::byte_t     mix_out [4];
	lfsc_pkg::byte_t     sub_out [4];
	lfsc_pkg::byte_t     t       [4];
	lfsc_pkg::byte_t     raw;
	logic [5:0]          sel     [8];

	always_comb begin
		fk = lfsc_pkg::fold_key(key);
		for (int k = 0; k < 4; k++) begin
			mix_out[k] = lfsc_pkg::rotl8(mix[k+7], 3'd2) ^ mix[k];
			t[k]       = fk[k] ^ fifo[k];
			sub_out[k] = {lfsc_pkg::NIB_SBOX[k][t[k][7:4]],
				lfsc_pkg::NIB_SBOX[k][t[k][3:0]]} ^ fk[k+4];
		end
		// per bit, six selector bits taken from lanes one to three
		for (int b = 0; b < 8; b++) begin
			sel[b] = {mix_out[1][b], sub_out[1][b], mix_out[2][b], sub_out[2][b],
				mix_out[3][b], sub_out[3][b]};
			raw[b] = lfsc_pkg::SIX_TO_ONE[sel[b]][b];
		end
		ks = lfsc_pkg::rotl8(raw ^ sub_out[0] ^ mix_out[0], pos);
	end

endmodule

// File: sv/lfsr_feedback_stream_cipher_top.sv
// top level of the lfsr feedback stream cipher: handshakes, sequencer and state
// depends on lfsc_pkg, lfsc_round and lfsc_keystream
//
// byte stream cipher with ciphertext feedback. each accepted transaction carries one
// byte and returns that byte xored with a keystream byte. a transaction runs through
// the accept cycle (which also seeds the mixing register and feedback fifo at the
// start of a message), 32 mixing rounds run one per cycle through the single shared
// round unit, and a finish step that forms the keystream byte and loads the output
// register. in_stall is high for the whole time a byte is in work. the finished byte
// sits in the output register, so the next byte can be accepted while it waits; if
// it is still not taken when the next byte finishes, the block holds in the finish
// step. the user must write the configuration port (cfg_index 0 key nibbles, 1
// encrypt mode) only while idle; the block itself does not enforce this.
module lfsr_feedback_stream_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_in_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MIX  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]         state_q;
	logic [4:0]         rc_q;          // round counter, counts down
	logic [63:0]        key_q;
	logic               mode_q;
	lfsc_pkg::mix_reg_t mix_q;
	lfsc_pkg::fifo_t    fifo_q;
	logic [2:0]         pos_q;
	logic               needs_seed_q;
	lfsc_pkg::byte_t    data_q;
	logic               last_q;
	logic               out_valid_q;
	lfsc_pkg::byte_t    out_byte_q;

	logic               in_take;
	logic               out_take;
	logic               fin_go;
	logic [3:0]         dst;
	lfsc_pkg::byte_t    new_byte;
	lfsc_pkg::byte_t    ks;
	lfsc_pkg::byte_t    result;
	lfsc_pkg::byte_t    fb;
	lfsc_pkg::fold_key_t fk_seed;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_take  = out_valid_q && !out_stall;
	// output slot is free, or emptied this cycle
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	lfsc_round u_round (
		.mix      (mix_q),
		.rc       (rc_q),
		.dst      (dst),
		.new_byte (new_byte)
	);

	lfsc_keystream u_keystream (
		.mix  (mix_q),
		.fifo (fifo_q),
		.key  (key_q),
		.pos  (pos_q),
		.ks   (ks)
	);

	assign fk_seed = lfsc_pkg::fold_key(key_q);
	assign result  = data_q ^ ks;
	// encrypt feeds back the output byte, decrypt the input byte
	assign fb      = mode_q ? result : data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lfsc_pkg::REG_KEY_NIBBLES:  key_q  <= cfg_data;
				lfsc_pkg::REG_ENCRYPT_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rc_q         <= '0;
			pos_q        <= '0;
			needs_seed_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_MIX;
						rc_q    <= 5'(lfsc_pkg::ROUNDS - 1);
						if (needs_seed_q) begin
							pos_q        <= '0;
							needs_seed_q <= 1'b0;
						end
					end
				end
				ST_MIX: begin
					rc_q <= rc_q - 5'd1;
					if (rc_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							needs_seed_q <= 1'b1;
							pos_q        <= '0;
						end else begin
							pos_q <= pos_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: mixing register, feedback fifo, latched input, output byte
	always_ff @(posedge clk) begin
		if (in_take) begin
			data_q <= data_byte;
			last_q <= last_in_message;
			if (needs_seed_q) begin
				for (int k = 0; k < lfsc_pkg::MIX_DEPTH - 1; k++) begin
					mix_q[k] <= lfsc_pkg::spread_nib(lfsc_pkg::key_nib(key_q, 4'(k)));
				end
				mix_q[lfsc_pkg::MIX_DEPTH-1] <= lfsc_pkg::SEED_TOP;
				for (int k = 0; k < lfsc_pkg::FIFO_DEPTH; k++) begin
					fifo_q[k] <= fk_seed[k] ^ fk_seed[k+4] ^ lfsc_pkg::FIFO_XOR;
				end
			end
		end
		if (state_q == ST_MIX) begin
			mix_q[dst] <= new_byte;
		end
		if (fin_go) begin
			out_byte_q <= result;
			for (int k = 0; k < lfsc_pkg::FIFO_DEPTH - 1; k++) begin
				fifo_q[k] <= lfsc_pkg::rotl8(fifo_q[k+1], 3'd1);
			end
			fifo_q[lfsc_pkg::FIFO_DEPTH-1] <= lfsc_pkg::rotl8(fb, 3'd1);
		end
	end

`ifndef SYNTHESIS
	// an accepted transaction always starts the full round count
	a_start_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_MIX) && (rc_q == 5'(lfsc_pkg::ROUNDS - 1)))
		else $error("round sequence did not start after accept");

	// last round leads straight to the finish step
	a_mix_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX) && (rc_q == '0) |=> (state_q == ST_FIN))
		else $error("mixing did not end after the last round");

	// a pending seed means the position is at message start
	a_seed_pos: assert property (@(posedge clk) disable iff (!arst_n)
		needs_seed_q |-> (pos_q == '0))
		else $error("position not cleared while seed is pending");

	// finishing always presents a result
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished transaction did not reach the output");
`endif

endmodule
